### hw/rtl/websocket_server_frame_parser_defines.svh
// ----------------------------------------------------------------------------
// websocket frame parser assertion macros
// shared assertion helpers, empty when built for synthesis
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_SERVER_FRAME_PARSER_DEFINES_SVH
`define WEBSOCKET_SERVER_FRAME_PARSER_DEFINES_SVH
`ifndef SYNTHESIS
`define WSFP_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("wsfp assertion failed");
`define WSFP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("wsfp assertion failed");
`else
`define WSFP_ASSERT(label, clk, rstn, prop)
`define WSFP_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

### hw/rtl/wsfp_pkg.sv
// ----------------------------------------------------------------------------
// wsfp_pkg
// types and constants of the websocket server frame parser
// ----------------------------------------------------------------------------
package wsfp_pkg;

    localparam int LENGTH_BITS = 64;
    localparam int CFG_W       = 64;
    localparam int PCNT_W      = 64;

    localparam logic [CFG_W-1:0] MAX_PAYLOAD_RST = CFG_W'(16777216);

    localparam logic [6:0] LEN7_CTRL_MAX = 7'd125;
    localparam logic [6:0] LEN7_EXT16    = 7'd126;
    localparam logic [6:0] LEN7_EXT64    = 7'd127;
    localparam logic [3:0] EXT16_BYTES   = 4'd2;
    localparam logic [3:0] EXT64_BYTES   = 4'd8;

    localparam logic [2:0] ERR_RSV_BITS   = 3'd0;
    localparam logic [2:0] ERR_MASKED     = 3'd1;
    localparam logic [2:0] ERR_CTRL_FRAG  = 3'd2;
    localparam logic [2:0] ERR_CTRL_LEN   = 3'd3;
    localparam logic [2:0] ERR_PAY_LEN    = 3'd4;
    localparam logic [2:0] ERR_FAILED     = 3'd5;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_PAY  = 3'd3,
        PH_FAIL = 3'd4
    } phase_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } ws_in_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_done;
        logic       fin_flag;
        logic [3:0] opcode;
        logic       error;
        logic [2:0] error_code;
    } ws_out_t;

endpackage

### hw/rtl/wsfp_in_reg.sv
// ----------------------------------------------------------------------------
// wsfp_in_reg
// input register of the frame parser, takes a transfer whenever it is free
// ----------------------------------------------------------------------------
module wsfp_in_reg
    import wsfp_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  ws_in_t s_data,
    input  logic   advance,
    output logic   item_valid,
    output ws_in_t item
);

    logic   vld_reg;
    logic   vld_next;
    ws_in_t data_reg;

    assign s_ready    = !vld_reg || advance;
    assign vld_next   = s_valid || (vld_reg && !advance);
    assign item_valid = vld_reg;
    assign item       = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_ready) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

### hw/rtl/wsfp_parser.sv
// ----------------------------------------------------------------------------
// wsfp_parser
// frame state and single pass parse of one byte into one result
// ----------------------------------------------------------------------------
`include "websocket_server_frame_parser_defines.svh"

module wsfp_parser
    import wsfp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  ws_in_t           item,
    input  logic [CFG_W-1:0] max_payload,
    output ws_out_t          result
);

    phase_t                 phase_reg, phase_next;
    logic                   fin_reg, fin_next;
    logic [3:0]             op_reg, op_next;
    logic [LENGTH_BITS-1:0] flen_reg, flen_next;
    logic [3:0]             need_reg, need_next;
    logic [3:0]             seen_reg, seen_next;
    logic [PCNT_W-1:0]      pcnt_reg, pcnt_next;

    logic [7:0]             c;
    logic [6:0]             len7;
    logic [LENGTH_BITS-1:0] flen_shift;
    logic [3:0]             seen_inc;
    logic [PCNT_W-1:0]      pcnt_inc;

    assign c          = item.data_byte;
    assign len7       = c[6:0];
    assign flen_shift = {flen_reg[LENGTH_BITS-9:0], c};
    assign seen_inc   = seen_reg + 4'd1;
    assign pcnt_inc   = pcnt_reg + PCNT_W'(1);

    always_comb begin
        phase_next = phase_reg;
        fin_next   = fin_reg;
        op_next    = op_reg;
        flen_next  = flen_reg;
        need_next  = need_reg;
        seen_next  = seen_reg;
        pcnt_next  = pcnt_reg;
        result     = '0;
        if (item.mode) begin
            phase_next = PH_HDR0;
            fin_next   = 1'b0;
            op_next    = 4'd0;
            flen_next  = '0;
            need_next  = 4'd0;
            seen_next  = 4'd0;
            pcnt_next  = '0;
        end else begin
            case (phase_reg)
                PH_HDR0: begin
                    fin_next  = c[7];
                    op_next   = c[3:0];
                    flen_next = '0;
                    pcnt_next = '0;
                    need_next = 4'd0;
                    seen_next = 4'd0;
                    if (|c[6:4]) begin
                        phase_next        = PH_FAIL;
                        result.error      = 1'b1;
                        result.error_code = ERR_RSV_BITS;
                    end else begin
                        phase_next = PH_HDR1;
                    end
                end
                PH_HDR1: begin
                    if (c[7]) begin
                        phase_next        = PH_FAIL;
                        result.error      = 1'b1;
                        result.error_code = ERR_MASKED;
                    end else if (op_reg[3] && !fin_reg) begin
                        phase_next        = PH_FAIL;
                        result.error      = 1'b1;
                        result.error_code = ERR_CTRL_FRAG;
                    end else if (op_reg[3] && (len7 > LEN7_CTRL_MAX)) begin
                        phase_next        = PH_FAIL;
                        result.error      = 1'b1;
                        result.error_code = ERR_CTRL_LEN;
                    end else if ((len7 == LEN7_EXT16) || (len7 == LEN7_EXT64)) begin
                        need_next  = (len7 == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                        seen_next  = 4'd0;
                        flen_next  = '0;
                        phase_next = PH_EXT;
                    end else if (len7 != 7'd0) begin
                        flen_next  = LENGTH_BITS'(len7);
                        pcnt_next  = '0;
                        phase_next = PH_PAY;
                    end else begin
                        flen_next         = '0;
                        phase_next        = PH_HDR0;
                        result.frame_done = 1'b1;
                    end
                end
                PH_EXT: begin
                    flen_next = flen_shift;
                    seen_next = seen_inc;
                    if (seen_inc >= need_reg) begin
                        if (CFG_W'(flen_shift) > max_payload) begin
                            phase_next        = PH_FAIL;
                            result.error      = 1'b1;
                            result.error_code = ERR_PAY_LEN;
                        end else if (flen_shift != '0) begin
                            pcnt_next  = '0;
                            phase_next = PH_PAY;
                        end else begin
                            phase_next        = PH_HDR0;
                            result.frame_done = 1'b1;
                        end
                    end
                end
                PH_PAY: begin
                    result.payload_byte  = c;
                    result.payload_valid = 1'b1;
                    pcnt_next            = pcnt_inc;
                    if (pcnt_inc == PCNT_W'(flen_reg)) begin
                        phase_next        = PH_HDR0;
                        result.frame_done = 1'b1;
                    end
                end
                default: begin
                    phase_next        = PH_FAIL;
                    result.error      = 1'b1;
                    result.error_code = ERR_FAILED;
                end
            endcase
        end
        result.fin_flag = fin_next;
        result.opcode   = op_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HDR0;
            fin_reg   <= 1'b0;
            op_reg    <= 4'd0;
            flen_reg  <= '0;
            need_reg  <= 4'd0;
            seen_reg  <= 4'd0;
            pcnt_reg  <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            fin_reg   <= fin_next;
            op_reg    <= op_next;
            flen_reg  <= flen_next;
            need_reg  <= need_next;
            seen_reg  <= seen_next;
            pcnt_reg  <= pcnt_next;
        end
    end

    // failed parser leaves only on clear
    `WSFP_ASSERT(a_fail_sticky, aclk, aresetn, (advance && phase_reg == PH_FAIL && !item.mode) |=> (phase_reg == PH_FAIL))
    // payload count stays below the frame length while in payload
    `WSFP_ASSERT(a_pay_count, aclk, aresetn, (phase_reg == PH_PAY) |-> (pcnt_reg < PCNT_W'(flen_reg)))
    // extended length only ever needs two or eight bytes
    `WSFP_ASSERT(a_ext_need, aclk, aresetn, (phase_reg == PH_EXT) |-> (need_reg == EXT16_BYTES || need_reg == EXT64_BYTES))

endmodule

### hw/rtl/websocket_server_frame_parser.sv
// ----------------------------------------------------------------------------
// websocket_server_frame_parser
// top level: input register, single pass parser, result register, max_payload
// ----------------------------------------------------------------------------
// Takes one byte of an unmasked server-to-client websocket stream per input
// transfer and gives exactly one result transfer for it. Throughput is one
// byte per clock while the result side is not stalled; each byte passes the
// input register, the combinational parse logic (64-bit length shift,
// compare against max_payload and payload count increment) and the result
// register in that order. A stalled result register holds the input register,
// which still takes one more byte. max_payload is written over the cfg
// channel, which is always ready; write it only while no byte is in flight.
`include "websocket_server_frame_parser_defines.svh"

module websocket_server_frame_parser
    import wsfp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ws_in_t           s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ws_out_t          m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data
);

    logic             item_valid;
    ws_in_t           item;
    logic             advance;
    ws_out_t          result;
    logic             m_valid_reg;
    ws_out_t          m_data_reg;
    logic [CFG_W-1:0] max_payload_reg;

    assign advance   = item_valid && (!m_valid_reg || m_ready);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    wsfp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    wsfp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .item        (item),
        .max_payload (max_payload_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RST;
        end else if (cfg_valid && cfg_ready) begin
            max_payload_reg <= cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= result;
        end
    end

    // an error result never carries payload or frame end
    `WSFP_ASSERT(a_err_excl, aclk, aresetn, m_valid |-> !(m_data.error && (m_data.payload_valid || m_data.frame_done)))
    // error code is zero without an error
    `WSFP_ASSERT(a_code_zero, aclk, aresetn, (m_valid && !m_data.error) |-> (m_data.error_code == ERR_RSV_BITS))
    // a full input register with a stalled result takes no transfer
    `WSFP_ASSERT(a_no_overrun, aclk, aresetn, (item_valid && m_valid && !m_ready) |-> !s_ready)

endmodule

### sim/websocket_server_frame_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// websocket_server_frame_parser_test
// byte-stream regression for the websocket server frame parser
// ----------------------------------------------------------------------------
// Feeds the parser a short directed set of frames and errors, then random
// well-formed frames mixed with broken headers, stray bytes and clears,
// under four max_payload settings. A scoreboard predicts each result from
// the accepted bytes and checks every result field in order. Both sides
// idle at random; one phase runs without idling and one holds off the
// result side long enough to back up the input.
// ----------------------------------------------------------------------------
module websocket_server_frame_parser_test
    import wsfp_pkg::*;
();

    localparam logic [63:0] LEN_MASK        = {64{1'b1}} >> (64 - LENGTH_BITS);
    localparam int          SETTLE_CYCLES   = 8;
    localparam int          HOLD_OFF_CYCLES = 120;
    localparam int          WATCHDOG_LIMIT  = 1000;

    localparam logic [3:0] OP_CONT   = 4'h0;
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    class frame_scoreboard;
        phase_t      phase;
        logic        held_fin;
        logic [3:0]  held_opcode;
        logic [63:0] frame_length;
        logic [3:0]  ext_needed;
        logic [3:0]  ext_seen;
        logic [63:0] payload_count;
        logic [63:0] max_payload;
        ws_out_t     pending[$];
        int unsigned mismatches;

        function new();
            clear_parser();
            max_payload = MAX_PAYLOAD_RST;
            mismatches  = 0;
        endfunction

        function void clear_parser();
            phase         = PH_HDR0;
            held_fin      = 1'b0;
            held_opcode   = '0;
            frame_length  = '0;
            ext_needed    = '0;
            ext_seen      = '0;
            payload_count = '0;
        endfunction

        function void note_byte(ws_in_t item);
            ws_out_t    r;
            logic [7:0] c;
            logic       failed;
            logic [2:0] code;
            c      = item.data_byte;
            r      = '0;
            failed = 1'b0;
            code   = ERR_RSV_BITS;
            if (item.mode) begin
                clear_parser();
            end else begin
                case (phase)
                    PH_HDR0: begin
                        held_fin      = c[7];
                        held_opcode   = c[3:0];
                        frame_length  = '0;
                        payload_count = '0;
                        ext_needed    = '0;
                        ext_seen      = '0;
                        if (c[6:4] != 3'b000) begin
                            failed = 1'b1;
                            code   = ERR_RSV_BITS;
                        end else begin
                            phase = PH_HDR1;
                        end
                    end
                    PH_HDR1: begin
                        if (c[7]) begin
                            failed = 1'b1;
                            code   = ERR_MASKED;
                        end else if (held_opcode[3] && !held_fin) begin
                            failed = 1'b1;
                            code   = ERR_CTRL_FRAG;
                        end else if (held_opcode[3] && c[6:0] > LEN7_CTRL_MAX) begin
                            failed = 1'b1;
                            code   = ERR_CTRL_LEN;
                        end else if (c[6:0] == LEN7_EXT16 || c[6:0] == LEN7_EXT64) begin
                            ext_needed   = (c[6:0] == LEN7_EXT16) ? EXT16_BYTES : EXT64_BYTES;
                            ext_seen     = '0;
                            frame_length = '0;
                            phase        = PH_EXT;
                        end else if (c[6:0] != 7'd0) begin
                            frame_length  = 64'(c[6:0]);
                            payload_count = '0;
                            phase         = PH_PAY;
                        end else begin
                            frame_length = '0;
                            phase        = PH_HDR0;
                            r.frame_done = 1'b1;
                        end
                    end
                    PH_EXT: begin
                        frame_length = ((frame_length << 8) | 64'(c)) & LEN_MASK;
                        ext_seen     = ext_seen + 4'd1;
                        if (ext_seen >= ext_needed) begin
                            if (frame_length > max_payload) begin
                                failed = 1'b1;
                                code   = ERR_PAY_LEN;
                            end else if (frame_length != 0) begin
                                payload_count = '0;
                                phase         = PH_PAY;
                            end else begin
                                phase        = PH_HDR0;
                                r.frame_done = 1'b1;
                            end
                        end
                    end
                    PH_PAY: begin
                        r.payload_byte  = c;
                        r.payload_valid = 1'b1;
                        payload_count   = payload_count + 64'd1;
                        if (payload_count == frame_length) begin
                            phase        = PH_HDR0;
                            r.frame_done = 1'b1;
                        end
                    end
                    default: begin
                        failed = 1'b1;
                        code   = ERR_FAILED;
                    end
                endcase
            end
            if (failed) begin
                phase        = PH_FAIL;
                r.error      = 1'b1;
                r.error_code = code;
            end
            r.fin_flag = held_fin;
            r.opcode   = held_opcode;
            pending = {pending, r};
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(ws_out_t got);
            ws_out_t want;
            if (pending.size() == 0) begin
                $error("result %h with no byte waiting for it", got);
                mismatches++;
                return;
            end
            want = pending.pop_front();
            compare_field("payload_byte", want.payload_byte, got.payload_byte);
            compare_field("payload_valid", 8'(want.payload_valid), 8'(got.payload_valid));
            compare_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
            compare_field("fin_flag", 8'(want.fin_flag), 8'(got.fin_flag));
            compare_field("opcode", 8'(want.opcode), 8'(got.opcode));
            compare_field("error", 8'(want.error), 8'(got.error));
            compare_field("error_code", 8'(want.error_code), 8'(got.error_code));
        endfunction
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    ws_in_t            s_data;
    logic              m_valid;
    logic              m_ready;
    ws_out_t           m_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_data;

    frame_scoreboard   sb;
    int unsigned       bytes_sent;
    int unsigned       quiet_cycles;
    logic              idling_on;
    logic              hold_off_req;

    websocket_server_frame_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // transfer monitor: bytes in, results out, register writes
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_byte(s_data);
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_data);
        end
        if (aresetn && cfg_valid && cfg_ready) begin
            sb.max_payload = cfg_data;
        end
        if (aresetn && ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
    end

    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end
            m_ready = !(idling_on && $urandom_range(99) < 24);
        end
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_byte(input logic mode, input logic [7:0] b);
        while (idling_on && $urandom_range(99) < 24) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid          = 1'b1;
        s_data.mode      = mode;
        s_data.data_byte = b;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
        @(negedge aclk);
    endtask

    task automatic send_frame(input logic [7:0] hdr, input logic [7:0] len_byte,
                              input logic [63:0] ext_len, input int unsigned n_payload);
        int n_ext;
        n_ext = (len_byte[6:0] == LEN7_EXT64) ? int'(EXT64_BYTES) :
                (len_byte[6:0] == LEN7_EXT16) ? int'(EXT16_BYTES) : 0;
        send_byte(1'b0, hdr);
        send_byte(1'b0, len_byte);
        for (int i = n_ext - 1; i >= 0; i--) begin
            send_byte(1'b0, ext_len[8*i +: 8]);
        end
        repeat (n_payload) send_byte(1'b0, 8'($urandom));
    endtask

    task automatic send_random_frame();
        logic [3:0]  op;
        logic        fin;
        logic [7:0]  len_byte;
        logic [63:0] len;
        int unsigned pick;
        int unsigned n_payload;
        pick = $urandom_range(99);
        case ($urandom_range(5))
            0: op = OP_CONT;
            1: op = OP_TEXT;
            2: op = OP_BINARY;
            3: op = OP_CLOSE;
            4: op = OP_PING;
            default: op = OP_PONG;
        endcase
        if (pick < 8) begin
            op = 4'($urandom);
        end
        fin = op[3] ? 1'b1 : 1'($urandom_range(1));
        len = 64'($urandom_range(op[3] ? 10 : 24));
        if (op[3] && pick >= 92) begin
            len = 64'(LEN7_CTRL_MAX);
        end
        len_byte = {1'b0, len[6:0]};
        if (!op[3] && pick >= 55) begin
            len_byte = {1'b0, (pick >= 80) ? LEN7_EXT64 : LEN7_EXT16};
            len = (pick >= 94) ? {$urandom, $urandom} : 64'($urandom_range(40));
            if (len_byte[6:0] == LEN7_EXT16) begin
                len = {48'd0, len[15:0]};
            end
        end
        // long frames are cut short and are cleared afterwards on three of four draws
        n_payload = (len > 64'd32) ? $urandom_range(1, 8) : int'(len);
        send_frame({fin, 3'b000, op}, len_byte, len, n_payload);
    endtask

    task automatic send_broken_frame();
        logic [3:0] op;
        op = 4'($urandom);
        case ($urandom_range(3))
            0: send_byte(1'b0, {1'($urandom), 3'($urandom_range(1, 7)), op});
            1: begin
                send_byte(1'b0, {1'b1, 3'b000, op});
                send_byte(1'b0, {1'b1, 7'($urandom)});
            end
            2: begin
                send_byte(1'b0, {1'b0, 3'b000, 1'b1, op[2:0]});
                send_byte(1'b0, {1'b0, 7'($urandom)});
            end
            default: begin
                send_byte(1'b0, {1'b1, 3'b000, 1'b1, op[2:0]});
                send_byte(1'b0, {1'b0, 7'($urandom_range(126, 127))});
            end
        endcase
        repeat ($urandom_range(0, 3)) send_byte(1'b0, 8'($urandom));
    endtask

    task automatic wait_for_idle();
        s_valid = 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_max_payload(input logic [CFG_W-1:0] value);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_traffic(input int unsigned n_bytes);
        int unsigned stop_at;
        int unsigned pick;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                send_random_frame();
            end else if (pick < 90) begin
                send_broken_frame();
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_byte(1'($urandom_range(9) == 0), 8'($urandom));
                end
            end
            if (sb.phase != PH_HDR0 && $urandom_range(3) != 0) begin
                send_byte(1'b1, 8'($urandom));
            end
        end
        wait_for_idle();
    endtask

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data       = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        idling_on    = 1'b1;
        hold_off_req = 1'b0;
        bytes_sent   = 0;
        quiet_cycles = 0;
        sb           = new();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // clear with data ignored, zero-length frame, one-byte ping
        send_byte(1'b1, 8'hFF);
        send_byte(1'b0, {1'b1, 3'b000, OP_TEXT});
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, {1'b1, 3'b000, OP_PING});
        send_byte(1'b0, 8'h01);
        send_byte(1'b0, 8'hFF);
        // reserved bits, then a byte in the failed state
        send_byte(1'b0, {1'b0, 3'b111, OP_CONT});
        send_byte(1'b0, 8'h55);
        send_byte(1'b1, 8'h00);
        // masked length
        send_byte(1'b0, {1'b1, 3'b000, OP_BINARY});
        send_byte(1'b0, {1'b1, LEN7_EXT64});
        send_byte(1'b1, 8'h00);
        // fragmented close
        send_byte(1'b0, {1'b0, 3'b000, OP_CLOSE});
        send_byte(1'b0, 8'h00);
        send_byte(1'b1, 8'h00);
        // control frame with extended length code
        send_byte(1'b0, {1'b1, 3'b000, OP_PONG});
        send_byte(1'b0, {1'b0, LEN7_EXT64});
        send_byte(1'b1, 8'h00);
        // largest 64-bit length against the reset limit
        send_frame({1'b1, 3'b000, OP_BINARY}, {1'b0, LEN7_EXT64}, {64{1'b1}}, 0);
        send_byte(1'b1, 8'h00);
        wait_for_idle();

        write_max_payload(64'd30);
        hold_off_req = 1'b1;
        run_traffic(300);

        write_max_payload(64'd0);
        run_traffic(200);

        write_max_payload({CFG_W{1'b1}});
        idling_on = 1'b0;
        run_traffic(300);
        idling_on = 1'b1;

        write_max_payload(MAX_PAYLOAD_RST);
        run_traffic(350);

        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/wsfp_pkg.sv
hw/rtl/wsfp_in_reg.sv
hw/rtl/wsfp_parser.sv
hw/rtl/websocket_server_frame_parser.sv
sim/websocket_server_frame_parser_test.sv
